// File: rtl/icer_pkg.sv
// Shared types, codes and helpers for the ICMP echo responder.
`timescale 1ns / 1ps

package icer_pkg;

    localparam int NUM_LANES = 4;
    localparam int LEN_W     = 10;

    localparam logic [1:0] KIND_IGNORED = 2'd0;
    localparam logic [1:0] KIND_MATCHED = 2'd1;
    localparam logic [1:0] KIND_REPLY   = 2'd2;

    localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;

    localparam logic [63:0] HDR_MASK = 64'h00FF_0000_FFFF_FFFF;

    typedef enum logic [1:0] {
        ST_RECV,
        ST_DECIDE,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    typedef struct packed {
        logic [15:0] keep;
        logic [15:0] sum;
    } lane_out_t;

    function automatic logic [15:0] fold16(input logic [19:0] s);
        logic [16:0] t;
        t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

// File: rtl/icmp_echo_responder_core.sv
// Top level of the ICMP echo responder: receive, decide and reply sequencer.
// Status results are loaded in the decide state that follows a packet's last chunk;
// echo reply words pass the buffer read and write states. Throughput: one chunk or
// arm per cycle while receiving; a reply word is a buffer read, then an output load.
// No input is taken from a packet's last chunk until all its results are loaded.
// Reset: aresetn clears control state and flags; the packet buffer is not cleared.
`timescale 1ns / 1ps

module icmp_echo_responder_core
    import icer_pkg::*;
#(
    parameter int MAX_BYTES = 512
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // chunk_data[63:0], chunk_bytes[67:64], peer_address[99:68],
    // arm_identifier[115:100], arm_sequence[131:116], zero fill[135:132]
    input  logic [135:0] s_tdata,
    input  logic         s_tlast,   // chunk_last
    input  logic         s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    // reply_data[63:0], reply_bytes[67:64], reply_destination[99:68],
    // reply_length[109:100], ping_answered[110], zero fill[111]
    output logic [111:0] m_tdata,
    output logic         m_tlast,   // reply_last
    output logic [1:0]   m_tuser    // kind
);

    localparam int BUF_WORDS = (MAX_BYTES + 7) / 8;
    localparam int ADDR_W    = $clog2(BUF_WORDS);
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic              oversize_reg, oversize_next;
    logic [19:0]       sum_reg, sum_next;
    logic [63:0]       header_reg, header_next;
    logic              pending_reg, pending_next;
    logic [15:0]       pend_id_reg, pend_id_next;
    logic [15:0]       pend_seq_reg, pend_seq_next;
    logic              replied_reg, replied_next;
    logic [31:0]       dest_reg, dest_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_kind_reg, m_kind_next;
    logic [63:0]       m_data_reg, m_data_next;
    logic [3:0]        m_bytes_reg, m_bytes_next;
    logic              m_last_reg, m_last_next;
    logic [31:0]       m_dest_reg, m_dest_next;
    logic [LEN_W-1:0]  m_len_reg, m_len_next;
    logic              m_replied_reg, m_replied_next;

    logic              s_hs;
    logic [3:0]        n_eff;
    logic [CNT_W:0]    total;
    logic              too_big;
    logic              first;
    logic              store;
    logic              out_free;
    logic              hit;
    logic              last_word;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  rem;
    logic [15:0]       ck;
    logic [7:0]        pkt_type;
    logic [63:0]       chunk_word;
    logic [19:0]       sum_new;
    logic [63:0]       ram_rd_data;
    logic              ram_rd_en;

    lane_out_t [NUM_LANES-1:0] lanes;

    assign s_tready = (state_reg == ST_RECV);
    assign s_hs     = s_tvalid && s_tready;
    assign first    = (byte_count_reg == '0);

    always_comb begin
        n_eff = 4'd8;
        if (s_tlast) begin
            n_eff = (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];
        end
    end

    assign total   = {1'b0, byte_count_reg} + (CNT_W + 1)'(n_eff);
    assign too_big = (total > (CNT_W + 1)'(MAX_BYTES));
    assign store   = s_hs && !s_tuser && (n_eff != 4'd0) && !too_big;

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++) begin : g_lane
            icer_lane u_lane (
                .lane_idx (2'(g)),
                .half     (s_tdata[63-16*g -: 16]),
                .n_bytes  (n_eff),
                .first    (first),
                .lane_out (lanes[g])
            );
        end
    endgenerate

    icer_merge u_merge (
        .lanes   (lanes),
        .sum_in  (sum_reg),
        .sum_out (sum_new)
    );

    icer_pack u_pack (
        .lanes (lanes),
        .word  (chunk_word)
    );

    icer_ram #(
        .WIDTH (64),
        .DEPTH (BUF_WORDS)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (store),
        .wr_addr (ADDR_W'(byte_count_reg >> 3)),
        .wr_data (chunk_word),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    assign out_free  = !m_valid_reg || m_tready;
    assign ck        = ~fold16(sum_reg);
    assign pkt_type  = header_reg[63:56];
    assign hit       = pending_reg && (header_reg[31:16] == pend_id_reg)
                       && (header_reg[15:0] == pend_seq_reg);
    assign cnt_m1    = byte_count_reg - 1'b1;
    assign last_word = (CNT_W'(idx_reg) == (cnt_m1 >> 3));
    assign rem       = byte_count_reg - (CNT_W'(idx_reg) << 3);

    always_comb begin
        state_next      = state_reg;
        byte_count_next = byte_count_reg;
        oversize_next   = oversize_reg;
        sum_next        = sum_reg;
        header_next     = header_reg;
        pending_next    = pending_reg;
        pend_id_next    = pend_id_reg;
        pend_seq_next   = pend_seq_reg;
        replied_next    = replied_reg;
        dest_next       = dest_reg;
        idx_next        = idx_reg;
        ram_rd_en       = 1'b0;

        m_valid_next    = m_valid_reg && !m_tready;
        m_kind_next     = m_kind_reg;
        m_data_next     = m_data_reg;
        m_bytes_next    = m_bytes_reg;
        m_last_next     = m_last_reg;
        m_dest_next     = m_dest_reg;
        m_len_next      = m_len_reg;
        m_replied_next  = m_replied_reg;

        unique case (state_reg)
            ST_RECV: begin
                if (s_hs) begin
                    if (s_tuser) begin
                        pend_id_next  = s_tdata[115:100];
                        pend_seq_next = s_tdata[131:116];
                        replied_next  = 1'b0;
                        pending_next  = 1'b1;
                    end else begin
                        if (n_eff != 4'd0) begin
                            if (too_big) begin
                                oversize_next = 1'b1;
                            end else begin
                                byte_count_next = total[CNT_W-1:0];
                                sum_next        = sum_new;
                                if (first) begin
                                    header_next = chunk_word;
                                end
                            end
                        end
                        if (s_tlast) begin
                            dest_next  = s_tdata[99:68];
                            state_next = ST_DECIDE;
                        end
                    end
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    m_kind_next    = KIND_IGNORED;
                    m_data_next    = '0;
                    m_bytes_next   = 4'd0;
                    m_last_next    = 1'b1;
                    m_dest_next    = '0;
                    m_len_next     = '0;
                    m_replied_next = replied_reg;
                    if (!oversize_reg && byte_count_reg < CNT_W'(8)) begin
                        m_valid_next = 1'b1;
                        state_next   = ST_RECV;
                    end else if (pkt_type == TYPE_ECHO_REPLY) begin
                        m_valid_next = 1'b1;
                        state_next   = ST_RECV;
                        if (hit) begin
                            m_kind_next    = KIND_MATCHED;
                            m_replied_next = 1'b1;
                            replied_next   = 1'b1;
                            pending_next   = 1'b0;
                        end
                    end else if (pkt_type != TYPE_ECHO_REQUEST || oversize_reg) begin
                        m_valid_next = 1'b1;
                        state_next   = ST_RECV;
                    end else begin
                        idx_next   = '0;
                        state_next = ST_EMIT_RD;
                    end
                    if (state_next == ST_RECV) begin
                        byte_count_next = '0;
                        oversize_next   = 1'b0;
                        sum_next        = '0;
                        header_next     = '0;
                    end
                end
            end
            ST_EMIT_RD: begin
                ram_rd_en  = 1'b1;
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_kind_next    = KIND_REPLY;
                    m_data_next    = ram_rd_data;
                    if (idx_reg == '0) begin
                        m_data_next = (header_reg & HDR_MASK) | {16'h0000, ck, 32'h0};
                    end
                    m_bytes_next   = last_word ? rem[3:0] : 4'd8;
                    m_last_next    = last_word;
                    m_dest_next    = dest_reg;
                    m_len_next     = LEN_W'(byte_count_reg);
                    m_replied_next = replied_reg;
                    if (last_word) begin
                        byte_count_next = '0;
                        oversize_next   = 1'b0;
                        sum_next        = '0;
                        header_next     = '0;
                        state_next      = ST_RECV;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_RECV;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RECV;
            byte_count_reg <= '0;
            oversize_reg   <= 1'b0;
            sum_reg        <= '0;
            header_reg     <= '0;
            pending_reg    <= 1'b0;
            pend_id_reg    <= '0;
            pend_seq_reg   <= '0;
            replied_reg    <= 1'b0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            oversize_reg   <= oversize_next;
            sum_reg        <= sum_next;
            header_reg     <= header_next;
            pending_reg    <= pending_next;
            pend_id_reg    <= pend_id_next;
            pend_seq_reg   <= pend_seq_next;
            replied_reg    <= replied_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dest_reg      <= dest_next;
        m_kind_reg    <= m_kind_next;
        m_data_reg    <= m_data_next;
        m_bytes_reg   <= m_bytes_next;
        m_last_reg    <= m_last_next;
        m_dest_reg    <= m_dest_next;
        m_len_reg     <= m_len_next;
        m_replied_reg <= m_replied_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_replied_reg, m_len_reg, m_dest_reg, m_bytes_reg, m_data_reg};

endmodule

// File: rtl/icer_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module icer_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/icer_lane.sv
// One 16-bit lane of a chunk: byte masking and checksum contribution.
`timescale 1ns / 1ps

module icer_lane
    import icer_pkg::*;
(
    input  logic [1:0]  lane_idx,
    input  logic [15:0] half,
    input  logic [3:0]  n_bytes,
    input  logic        first,
    output lane_out_t   lane_out
);

    logic keep_hi;
    logic keep_lo;
    logic [15:0] masked;

    always_comb begin
        keep_hi  = ({1'b0, lane_idx, 1'b0} < n_bytes);
        keep_lo  = ({1'b0, lane_idx, 1'b1} < n_bytes);
        masked   = {keep_hi ? half[15:8] : 8'h00, keep_lo ? half[7:0] : 8'h00};
        lane_out.keep = masked;
        lane_out.sum  = masked;
        // drop type byte and checksum field from the sum of the header word
        if (first && lane_idx == 2'd0) begin
            lane_out.sum = {8'h00, masked[7:0]};
        end else if (first && lane_idx == 2'd1) begin
            lane_out.sum = 16'h0000;
        end
    end

endmodule

// File: rtl/icer_merge.sv
// Merge of the lane contributions into the running ones'-complement sum.
`timescale 1ns / 1ps

module icer_merge
    import icer_pkg::*;
(
    input  lane_out_t [NUM_LANES-1:0] lanes,
    input  logic [19:0]               sum_in,
    output logic [19:0]               sum_out
);

    logic [19:0] acc;

    always_comb begin
        acc = {4'd0, fold16(sum_in)};
        for (int i = 0; i < NUM_LANES; i++) begin
            acc = acc + {4'd0, lanes[i].sum};
        end
        sum_out = acc;
    end

endmodule

// File: rtl/icer_top_unused_guard.sv
// Word assembly of the lane outputs into one buffer word.
`timescale 1ns / 1ps

module icer_pack
    import icer_pkg::*;
(
    input  lane_out_t [NUM_LANES-1:0] lanes,
    output logic [63:0]               word
);

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            word[63-16*i -: 16] = lanes[i].keep;
        end
    end

endmodule
